// ----- src/sid_pkg.sv -----
// Package for the slot interrupt dispatcher: field widths, operation and
// result codes, and the result item structure.
// No dependencies; the interfaces and the top level import it.
`default_nettype none

package sid_pkg;

	// Fixed geometry of the slot registry.
	localparam int NUM_SLOTS = 16;
	localparam int SLOT_W    = 4;
	localparam int CLIENT_W  = 3;
	localparam int ARG_W     = 32;
	localparam int MASK_W    = 16;
	localparam int TIME_W    = 21;
	localparam int CNT_W     = 3;
	localparam int OFFS_W    = 4;

	// One slot lasts 12288 chipx8 = 3 * 4096. The time is shifted down by 12
	// and the remaining 9-bit quotient is divided by 3 with a reciprocal:
	// floor(x * 171 / 512) equals floor(x / 3) for every x below 512.
	localparam int          SLOT_SHIFT  = 12;
	localparam int          TQ_W        = TIME_W - SLOT_SHIFT;
	localparam int          RECIP_W     = 8;
	localparam int          RECIP_SHIFT = 9;
	localparam int          PROD_W      = TQ_W + RECIP_W;
	localparam logic [7:0]  RECIP3      = 8'd171;

	localparam logic [MASK_W-1:0] CLEAR_ALL = {MASK_W{1'b1}};

	typedef enum logic [1:0] {
		OP_REGISTER   = 2'd0,
		OP_DEREGISTER = 2'd1,
		OP_DEREG_ALL  = 2'd2,
		OP_INTERRUPT  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ACCEPTED  = 3'd0,
		KIND_REJECTED  = 3'd1,
		KIND_DISPATCH  = 3'd2,
		KIND_UNHANDLED = 3'd3,
		KIND_NONE      = 3'd4
	} kind_t;

	// One result item as it sits in the hold and output registers.
	typedef struct packed {
		kind_t               kind;
		logic [SLOT_W-1:0]   slot;
		logic [CLIENT_W-1:0] client;
		logic [ARG_W-1:0]    arg;
		logic [MASK_W-1:0]   enable;
		logic                active;
		logic [MASK_W-1:0]   clear;
		logic                last;
	} res_t;

endpackage

`default_nettype wire

// ----- src/sid_if.sv -----
// Channel interfaces of the slot interrupt dispatcher: the command channel
// and the result channel, each with valid/ready and its payload.
// Depends on sid_pkg.
`default_nettype none

interface sid_cmd_if;
	import sid_pkg::*;

	logic                valid;
	logic                ready;
	op_t                 op;
	logic [SLOT_W-1:0]   slot;
	logic [CLIENT_W-1:0] client;
	logic [ARG_W-1:0]    handler_arg;
	logic [MASK_W-1:0]   pending_mask;
	logic [TIME_W-1:0]   tx_time;

	modport source (
		output valid, op, slot, client, handler_arg, pending_mask, tx_time,
		input  ready
	);
	modport sink (
		input  valid, op, slot, client, handler_arg, pending_mask, tx_time,
		output ready
	);
endinterface

interface sid_res_if;
	import sid_pkg::*;

	logic                valid;
	logic                ready;
	kind_t               kind;
	logic [SLOT_W-1:0]   out_slot;
	logic [CLIENT_W-1:0] out_client;
	logic [ARG_W-1:0]    out_arg;
	logic [MASK_W-1:0]   enable_mask;
	logic                handler_active;
	logic [MASK_W-1:0]   clear_mask;
	logic                last;

	modport source (
		output valid, kind, out_slot, out_client, out_arg, enable_mask,
		       handler_active, clear_mask, last,
		input  ready
	);
	modport sink (
		input  valid, kind, out_slot, out_client, out_arg, enable_mask,
		       handler_active, clear_mask, last,
		output ready
	);
endinterface

`default_nettype wire

// ----- src/sid_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while the read enable is low. No dependencies.
`default_nettype none

module sid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/slot_interrupt_dispatcher.sv -----
// Top level of the slot interrupt dispatcher: command sequencer, per-slot
// registry update unit, interrupt walker and the result output register.
// Depends on sid_pkg, sid_cmd_if, sid_res_if and sid_ram.
//
//   Port       Direction  Carries
//   cmd        sink       register, deregister, deregister-all, interrupt
//   res        source     result transactions (accepted, rejected, dispatch, ...)
//   cfg_we     in         write strobe for frame_offset (cfg_wdata)
//
// Register and deregister pass through the update unit and then the finish
// state, a rejected command goes straight to the finish state; deregister for
// all slots runs the update unit once per slot, one slot per cycle.
// An interrupt first computes the current slot; then the walker visits one
// (slot, client) entry per cycle while the result channel does not stall,
// set by the one read port of the argument RAM, and a drain state follows.
// A stalled result channel freezes the walker; cmd.ready is high only when idle.
// Reset clears the registry flags and counts at once; no clearing pass.
`default_nettype none

module slot_interrupt_dispatcher #(
	parameter int NUM_CLIENTS = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [sid_pkg::OFFS_W-1:0]   cfg_wdata,
	sid_cmd_if.sink                           cmd,
	sid_res_if.source                         res
);
	import sid_pkg::*;

	localparam int NE  = NUM_SLOTS * NUM_CLIENTS;
	localparam int AW  = $clog2(NE);
	localparam int CIW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam logic [CIW-1:0]    KLAST = CIW'(NUM_CLIENTS - 1);
	localparam logic [SLOT_W-1:0] SLAST = SLOT_W'(NUM_SLOTS - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CUR,
		S_UPD,
		S_FIN,
		S_WALK,
		S_DRAIN
	} state_t;

	state_t              state_q;
	op_t                 op_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CIW-1:0]      client_q;
	logic [ARG_W-1:0]    arg_q;
	logic [MASK_W-1:0]   pend_q;
	logic [TQ_W-1:0]     tq_q;
	logic                rej_q;
	logic [OFFS_W-1:0]   offs_q;
	logic [SLOT_W-1:0]   cur_q;
	logic [SLOT_W-1:0]   pos_n_q;
	logic [CIW-1:0]      pos_k_q;
	logic [SLOT_W-1:0]   usl_q;

	// Registry state: one row of client valid bits per slot.
	logic [NUM_CLIENTS-1:0] ev_q [NUM_SLOTS];
	logic [CNT_W-1:0]    cnt_q [NUM_SLOTS];
	logic [MASK_W-1:0]   enable_q;
	logic                active_q;

	// Walker candidate stage, lookahead hold and output register.
	logic                c_v_s1;
	kind_t               c_kind_s1;
	logic [SLOT_W-1:0]   c_slot_s1;
	logic [CIW-1:0]      c_client_s1;
	logic                hold_v_q;
	res_t                hold_q;
	logic                out_vq;
	res_t                out_q;

	logic                advance;
	logic                accept;
	logic                client_ok;
	logic [MASK_W-1:0]   nz;
	logic                any_reg;

	logic [SLOT_W-1:0]   walk_sl;
	logic [AW-1:0]       walk_addr;
	logic                walk_c0;
	logic                cand_v;
	logic                walk_end;
	logic [ARG_W-1:0]    ram_rdata;
	logic                ram_re;
	logic                ram_we;
	res_t                s1_item;

	logic [SLOT_W-1:0]   upd_sl;
	logic [AW-1:0]       upd_addr;
	logic                upd_v;
	logic [CNT_W-1:0]    upd_cnt;
	logic [CNT_W-1:0]    cnt_new;

	logic [PROD_W-1:0]   tq_prod;
	logic [SLOT_W-1:0]   cur_next;

	logic                fin_empty;
	logic                push;
	res_t                push_item;

	// Handshake and registry summary.
	assign advance   = !out_vq || res.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign client_ok = (cmd.client < CLIENT_W'(NUM_CLIENTS));

	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			nz[i] = (cnt_q[i] != '0);
		end
	end
	assign any_reg = |nz;

	// Current slot from the transmit time: (time / 12288 - offset) mod 16.
	assign tq_prod  = PROD_W'(tq_q) * PROD_W'(RECIP3);
	assign cur_next = tq_prod[RECIP_SHIFT +: SLOT_W] - offs_q;

	// Walker: one (slot, client) entry per cycle while the result channel does not stall, starting after the current slot.
	assign walk_sl   = cur_q + pos_n_q + SLOT_W'(1);
	assign walk_addr = AW'(AW'(walk_sl) * AW'(NUM_CLIENTS) + AW'(pos_k_q));
	assign walk_c0   = nz[walk_sl];
	assign cand_v    = pend_q[walk_sl] &&
		(walk_c0 ? ev_q[walk_sl][pos_k_q] : (pos_k_q == '0));
	assign walk_end  = (pos_n_q == SLAST) && (pos_k_q == KLAST);
	assign ram_re    = (state_q == S_WALK) && advance;

	always_comb begin
		s1_item        = '0;
		s1_item.kind   = c_kind_s1;
		s1_item.slot   = c_slot_s1;
		s1_item.client = (c_kind_s1 == KIND_DISPATCH) ? CLIENT_W'(c_client_s1) : '0;
		s1_item.arg    = (c_kind_s1 == KIND_DISPATCH) ? ram_rdata : '0;
		s1_item.enable = enable_q;
		s1_item.active = active_q;
		s1_item.clear  = pend_q;
		s1_item.last   = 1'b0;
	end

	// Shared update unit: one slot entry of the registry per cycle.
	assign upd_sl   = (op_q == OP_DEREG_ALL) ? usl_q : slot_q;
	assign upd_addr = AW'(AW'(upd_sl) * AW'(NUM_CLIENTS) + AW'(client_q));
	assign upd_v    = ev_q[upd_sl][client_q];
	assign upd_cnt  = cnt_q[upd_sl];
	assign ram_we   = (state_q == S_UPD) && (op_q == OP_REGISTER);

	always_comb begin
		if (op_q == OP_REGISTER) begin
			cnt_new = upd_v ? upd_cnt : upd_cnt + CNT_W'(1);
		end else begin
			cnt_new = (upd_v && upd_cnt != '0) ? upd_cnt - CNT_W'(1) : upd_cnt;
		end
	end

	sid_ram #(
		.WIDTH (ARG_W),
		.DEPTH (NE)
	) u_arg_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (upd_addr),
		.wdata (arg_q),
		.re    (ram_re),
		.raddr (walk_addr),
		.rdata (ram_rdata)
	);

	// A removal that leaves nothing registered clears everything.
	assign fin_empty = !rej_q && (op_q != OP_REGISTER) && !any_reg;

	// Selection of the transaction pushed into the output register.
	always_comb begin
		push      = 1'b0;
		push_item = '0;
		case (state_q)
			S_FIN: begin
				push             = advance;
				push_item.kind   = rej_q ? KIND_REJECTED : KIND_ACCEPTED;
				push_item.enable = fin_empty ? '0 : enable_q;
				push_item.active = fin_empty ? 1'b0 : active_q;
				push_item.clear  = fin_empty ? CLEAR_ALL : '0;
				push_item.last   = 1'b1;
			end
			S_WALK: begin
				push      = advance && c_v_s1 && hold_v_q;
				push_item = hold_q;
			end
			S_DRAIN: begin
				if (c_v_s1) begin
					push      = advance && hold_v_q;
					push_item = hold_q;
				end else if (hold_v_q) begin
					push           = advance;
					push_item      = hold_q;
					push_item.last = 1'b1;
				end else begin
					push             = advance;
					push_item.kind   = KIND_NONE;
					push_item.enable = enable_q;
					push_item.active = active_q;
					push_item.clear  = pend_q;
					push_item.last   = 1'b1;
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	// Sequencer, registry and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_REGISTER;
			slot_q      <= '0;
			client_q    <= '0;
			arg_q       <= '0;
			pend_q      <= '0;
			tq_q        <= '0;
			rej_q       <= 1'b0;
			offs_q      <= '0;
			cur_q       <= '0;
			pos_n_q     <= '0;
			pos_k_q     <= '0;
			usl_q       <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				ev_q[i]  <= '0;
				cnt_q[i] <= '0;
			end
			enable_q    <= '0;
			active_q    <= 1'b0;
			c_v_s1      <= 1'b0;
			c_kind_s1   <= KIND_DISPATCH;
			c_slot_s1   <= '0;
			c_client_s1 <= '0;
			hold_v_q    <= 1'b0;
			hold_q      <= '0;
			out_vq      <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_we) begin
				offs_q <= cfg_wdata;
			end

			if (push) begin
				out_vq <= 1'b1;
				out_q  <= push_item;
			end else if (res.ready) begin
				out_vq <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q     <= cmd.op;
						slot_q   <= cmd.slot;
						client_q <= cmd.client[CIW-1:0];
						arg_q    <= cmd.handler_arg;
						pend_q   <= cmd.pending_mask;
						tq_q     <= cmd.tx_time[TIME_W-1:SLOT_SHIFT];
						usl_q    <= '0;
						if (cmd.op == OP_INTERRUPT) begin
							state_q <= S_CUR;
						end else if (!client_ok) begin
							rej_q   <= 1'b1;
							state_q <= S_FIN;
						end else begin
							state_q <= S_UPD;
						end
					end
				end
				S_CUR: begin
					cur_q    <= cur_next;
					pos_n_q  <= '0;
					pos_k_q  <= '0;
					c_v_s1   <= 1'b0;
					hold_v_q <= 1'b0;
					state_q  <= S_WALK;
				end
				S_UPD: begin
					ev_q[upd_sl][client_q] <= (op_q == OP_REGISTER);
					cnt_q[upd_sl]  <= cnt_new;
					if (op_q == OP_REGISTER) begin
						active_q <= 1'b1;
						if (cnt_new == CNT_W'(1)) begin
							enable_q[upd_sl] <= 1'b1;
						end
					end else if (cnt_new == '0) begin
						enable_q[upd_sl] <= 1'b0;
					end
					if (op_q == OP_DEREG_ALL && usl_q != SLAST) begin
						usl_q <= usl_q + SLOT_W'(1);
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (advance) begin
						if (fin_empty) begin
							enable_q <= '0;
							active_q <= 1'b0;
						end
						rej_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_WALK: begin
					if (advance) begin
						c_v_s1      <= cand_v;
						c_kind_s1   <= walk_c0 ? KIND_DISPATCH : KIND_UNHANDLED;
						c_slot_s1   <= walk_sl;
						c_client_s1 <= pos_k_q;
						if (c_v_s1) begin
							hold_q   <= s1_item;
							hold_v_q <= 1'b1;
						end
						if (pos_k_q == KLAST) begin
							pos_k_q <= '0;
							pos_n_q <= pos_n_q + SLOT_W'(1);
						end else begin
							pos_k_q <= pos_k_q + CIW'(1);
						end
						if (walk_end) begin
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					if (advance) begin
						c_v_s1 <= 1'b0;
						if (c_v_s1) begin
							hold_q   <= s1_item;
							hold_v_q <= 1'b1;
						end else begin
							hold_v_q <= 1'b0;
							state_q  <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result channel.
	assign res.valid          = out_vq;
	assign res.kind           = out_q.kind;
	assign res.out_slot       = out_q.slot;
	assign res.out_client     = out_q.client;
	assign res.out_arg        = out_q.arg;
	assign res.enable_mask    = out_q.enable;
	assign res.handler_active = out_q.active;
	assign res.clear_mask     = out_q.clear;
	assign res.last           = out_q.last;

`ifndef NO_ASSERTIONS
	// No walker item may be left behind when a new command is taken.
	a_idle_walker_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> (!hold_v_q && !c_v_s1))
		else $error("walker holds an item while idle");

	// Between commands a slot is enabled exactly when it has clients.
	a_enable_matches_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (enable_q == nz))
		else $error("enable mask disagrees with slot counts");

	// Between commands the handler-active flag tracks any registration.
	a_active_matches_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (active_q == any_reg))
		else $error("handler-active flag disagrees with slot counts");

	// Returning to idle always comes with the final transaction of the command.
	a_last_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && $past(state_q) != S_IDLE) |-> (out_vq && out_q.last))
		else $error("command finished without a final result");
`endif

endmodule

`default_nettype wire
